// ===== design/cpsat_pkg.sv =====
// Shared types and constants for the polygon overlap block.
`default_nettype none
package cpsat_pkg;
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_OVF   = 2'd2;

    // Job handed from the front end to the test engine.
    typedef struct packed {
        logic       empty;
        logic       ovf;
    } job_t;
endpackage
`default_nettype wire

// ===== design/cpsat_front.sv =====
// Front end: vertex loading, shape bookkeeping and job issue.
`default_nettype none
module cpsat_front #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_WIDTH  = 16,
    parameter int CW           = $clog2(MAX_VERTICES + 1),
    parameter int AW           = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire logic                   cmd,
    input  wire logic [COORD_WIDTH-1:0] vx,
    input  wire logic [COORD_WIDTH-1:0] vy,
    input  wire logic                   last,
    input  wire logic                   q_full,
    output logic                        we,
    output logic                        we_sel,
    output logic [AW-1:0]               waddr,
    output logic [2*COORD_WIDTH-1:0]    wdata,
    output logic                        job_push,
    output cpsat_pkg::job_t             job,
    output logic [CW-1:0]               cnt_a,
    output logic [CW-1:0]               cnt_b
);
    logic [CW-1:0] cnt_reg [2];
    logic [CW-1:0] cnt_next [2];
    logic [1:0] rst_flag_reg, rst_flag_next, ovf_reg, ovf_next;
    logic [CW-1:0] cur;

    // Counting and overflow tracking for the addressed shape
    always_comb
    begin
        cnt_next      = cnt_reg;
        rst_flag_next = rst_flag_reg;
        ovf_next      = ovf_reg;
        cur           = rst_flag_reg[cmd] ? '0 : cnt_reg[cmd];
        we            = 1'b0;
        if (load)
        begin
            if (rst_flag_reg[cmd])
                ovf_next[cmd] = 1'b0;
            rst_flag_next[cmd] = last;
            if (cur < CW'(MAX_VERTICES))
            begin
                we            = 1'b1;
                cnt_next[cmd] = cur + CW'(1);
            end
            else
            begin
                cnt_next[cmd] = cur;
                ovf_next[cmd] = 1'b1;
            end
        end
    end

    assign we_sel   = cmd;
    assign waddr    = cur[AW-1:0];
    assign wdata    = {vx, vy};
    assign job_push = load && cmd && last && !q_full;
    assign job.empty = (cnt_next[0] == '0) || (cnt_next[1] == '0);
    assign job.ovf   = ovf_next[0] || ovf_next[1];
    assign cnt_a = cnt_reg[0];
    assign cnt_b = cnt_reg[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg[0]   <= '0;
            cnt_reg[1]   <= '0;
            rst_flag_reg <= 2'b11;
            ovf_reg      <= 2'b00;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            rst_flag_reg <= rst_flag_next;
            ovf_reg      <= ovf_next;
        end
    end
endmodule
`default_nettype wire

// ===== design/cpsat_engine.sv =====
// Back end: vertex stores and sequenced separating-axis test.
`default_nettype none
module cpsat_engine #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_WIDTH  = 16,
    parameter int CW           = $clog2(MAX_VERTICES + 1),
    parameter int AW           = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   we,
    input  wire logic                   we_sel,
    input  wire logic [AW-1:0]          waddr,
    input  wire logic [2*COORD_WIDTH-1:0] wdata,
    input  wire logic                   job_valid,
    input  cpsat_pkg::job_t             job,
    input  wire logic [CW-1:0]          cnt_a,
    input  wire logic [CW-1:0]          cnt_b,
    output logic                        job_pop,
    output logic                        busy,
    output logic                        res_valid,
    output logic                        res_collide,
    output logic [1:0]                  res_status
);
    localparam int EW = COORD_WIDTH + 1;
    localparam int PW = COORD_WIDTH + EW + 1;
    localparam int DW = PW + 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_E0 = 6'b000010, S_E1 = 6'b000100,
        S_PROJ = 6'b001000, S_MUL = 6'b010000, S_CMP = 6'b100000
    } state_t;

    logic [2*COORD_WIDTH-1:0] mem_a [MAX_VERTICES];
    logic [2*COORD_WIDTH-1:0] mem_b [MAX_VERTICES];
    logic [2*COORD_WIDTH-1:0] rd_a_reg, rd_b_reg;
    logic [AW-1:0] ra, rb;

    state_t state_reg, state_next;
    logic esh_reg, esh_next;              // shape supplying the edge
    logic [CW-1:0] ei_reg, ei_next;       // edge index
    logic [CW-1:0] pi_reg, pi_next;       // projected vertex index
    logic          psh_reg, psh_next;     // projected shape
    logic          pfirst_reg, pfirst_next;
    logic signed [COORD_WIDTH-1:0] px_reg, px_next, py_reg, py_next;
    logic signed [EW-1:0] nx_reg, nx_next, ny_reg, ny_next;
    logic signed [PW-1:0] m1_reg, m1_next, m2_reg, m2_next;
    logic                 mv_reg, mv_next, msh_reg, mfirst_reg, mfirst_next;
    logic signed [DW-1:0] amn_reg, amn_next, amx_reg, amx_next;
    logic signed [DW-1:0] bmn_reg, bmn_next, bmx_reg, bmx_next;
    logic rv_next, rc_next;
    logic [1:0] rs_next;
    logic [CW-1:0] ne, np, en;
    logic signed [COORD_WIDTH-1:0] vx, vy;
    logic signed [DW-1:0] d;

    // Stores: one write port, one registered read each
    always_ff @(posedge clk)
    begin
        if (we && !we_sel)
            mem_a[waddr] <= wdata;
        if (we && we_sel)
            mem_b[waddr] <= wdata;
        rd_a_reg <= mem_a[ra];
        rd_b_reg <= mem_b[rb];
    end

    assign ne = esh_reg ? cnt_b : cnt_a;
    assign np = psh_reg ? cnt_b : cnt_a;
    assign en = (ei_reg + CW'(1) < ne) ? ei_reg + CW'(1) : '0;
    assign busy = (state_reg != S_IDLE);
    assign d = DW'(m1_reg) + DW'(m2_reg);

    // Sequencer: per edge fetch two vertices, then stream all vertices
    always_comb
    begin
        state_next = state_reg;
        esh_next = esh_reg; ei_next = ei_reg; pi_next = pi_reg;
        psh_next = psh_reg; pfirst_next = pfirst_reg;
        px_next = px_reg; py_next = py_reg; nx_next = nx_reg; ny_next = ny_reg;
        m1_next = m1_reg; m2_next = m2_reg; mv_next = 1'b0; mfirst_next = mfirst_reg;
        amn_next = amn_reg; amx_next = amx_reg; bmn_next = bmn_reg; bmx_next = bmx_reg;
        rv_next = 1'b0; rc_next = 1'b0; rs_next = cpsat_pkg::STATUS_OK;
        job_pop = 1'b0;
        ra = ei_reg[AW-1:0]; rb = ei_reg[AW-1:0];
        vx = '0; vy = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop = 1'b1;
                    if (job.empty || job.ovf)
                    begin
                        rv_next = 1'b1;
                        rs_next = job.empty ? cpsat_pkg::STATUS_EMPTY
                                            : cpsat_pkg::STATUS_OVF;
                    end
                    else
                    begin
                        esh_next = 1'b0; ei_next = '0;
                        state_next = S_E0;
                    end
                end
            end
            S_E0:
            begin
                ra = ei_reg[AW-1:0]; rb = ei_reg[AW-1:0];
                state_next = S_E1;
            end
            S_E1:
            begin
                {px_next, py_next} = esh_reg ? rd_b_reg : rd_a_reg;
                ra = en[AW-1:0]; rb = en[AW-1:0];
                state_next = S_MUL;
                pi_next = '0; psh_next = 1'b0;
            end
            S_MUL:
            begin
                // edge vector to normal
                {vx, vy} = esh_reg ? rd_b_reg : rd_a_reg;
                nx_next = EW'(py_reg) - EW'(vy);
                ny_next = EW'(vx) - EW'(px_reg);
                ra = '0; rb = '0;
                pi_next = CW'(1); pfirst_next = 1'b1;
                state_next = S_PROJ;
            end
            S_PROJ:
            begin
                // data for pi_reg-1 is in the read register
                {vx, vy} = psh_reg ? rd_b_reg : rd_a_reg;
                m1_next = PW'(vx) * PW'(nx_reg);
                m2_next = PW'(vy) * PW'(ny_reg);
                mv_next = 1'b1; mfirst_next = pfirst_reg;
                pfirst_next = 1'b0;
                if (pi_reg < np)
                begin
                    ra = pi_reg[AW-1:0]; rb = pi_reg[AW-1:0];
                    pi_next = pi_reg + CW'(1);
                end
                else if (!psh_reg)
                begin
                    psh_next = 1'b1; pfirst_next = 1'b1;
                    ra = '0; rb = '0; pi_next = CW'(1);
                end
                else
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                // last product is accumulated this cycle; compare next
                if (!mv_reg)
                begin
                    if (amx_reg < bmn_reg || bmx_reg < amn_reg || (esh_reg && en == '0))
                    begin
                        rv_next = 1'b1;
                        rc_next = !(amx_reg < bmn_reg || bmx_reg < amn_reg);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        if (en == '0) esh_next = 1'b1;
                        ei_next = en;
                        state_next = S_E0;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
        // min/max accumulation of the product stage
        if (mv_reg)
        begin
            if (!msh_reg)
            begin
                if (mfirst_reg || d < amn_reg) amn_next = d;
                if (mfirst_reg || d > amx_reg) amx_next = d;
            end
            else
            begin
                if (mfirst_reg || d < bmn_reg) bmn_next = d;
                if (mfirst_reg || d > bmx_reg) bmx_next = d;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
            res_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            res_valid <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        esh_reg <= esh_next; ei_reg <= ei_next; pi_reg <= pi_next;
        psh_reg <= psh_next; pfirst_reg <= pfirst_next;
        px_reg <= px_next; py_reg <= py_next; nx_reg <= nx_next; ny_reg <= ny_next;
        m1_reg <= m1_next; m2_reg <= m2_next; mfirst_reg <= mfirst_next;
        msh_reg <= psh_reg;
        amn_reg <= amn_next; amx_reg <= amx_next;
        bmn_reg <= bmn_next; bmx_reg <= bmx_next;
        res_collide <= rc_next; res_status <= rs_next;
    end
endmodule
`default_nettype wire

// ===== design/convex_polygon_sat_overlap.sv =====
// Top level of the convex polygon separating-axis overlap block.
// Usage: drive cmd, vertex_x, vertex_y, last and raise start; a transfer
// happens at an edge with start high and busy low. cmd=0 loads a vertex of
// the first shape, cmd=1 of the second. last=1 on a second-shape vertex
// queues a test job; the result appears on collide/status for one cycle
// with done high. The receiver cannot stall; results are never held.
// Empty or overflowed shapes are answered from idle, through the job queue
// register and the result register. Per axis, a full test runs the
// edge-vertex reads, the normal, the product pair of every vertex of both
// shapes from the stores, a product flush and the compare, over the edges
// of the first shape then the second, stopping at the first separating axis.
// busy stays high while a test runs, so no vertex can change the stores
// under it. Reset clears counts, overflow flags and the engine; the vertex
// stores are not cleared and are only read below the counts.
`default_nettype none
module convex_polygon_sat_overlap #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_WIDTH  = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic                   cmd,
    input  wire logic [COORD_WIDTH-1:0] vertex_x,
    input  wire logic [COORD_WIDTH-1:0] vertex_y,
    input  wire logic                   last,
    output logic                        done,
    output logic                        collide,
    output logic [1:0]                  status
);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    logic we, we_sel, job_push, job_pop, eng_busy, qv_reg;
    logic [AW-1:0] waddr;
    logic [2*COORD_WIDTH-1:0] wdata;
    cpsat_pkg::job_t job, q_reg;
    logic [CW-1:0] cnt_a, cnt_b;

    // Busy while a job waits or the engine runs
    assign busy = eng_busy || qv_reg;

    cpsat_front #(.MAX_VERTICES(MAX_VERTICES), .COORD_WIDTH(COORD_WIDTH),
                  .CW(CW), .AW(AW)) u_front (
        .clk(clk), .rst_n(rst_n), .load(start && !busy), .cmd(cmd),
        .vx(vertex_x), .vy(vertex_y), .last(last), .q_full(qv_reg),
        .we(we), .we_sel(we_sel), .waddr(waddr), .wdata(wdata),
        .job_push(job_push), .job(job), .cnt_a(cnt_a), .cnt_b(cnt_b));

    // One-entry job queue between front and back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            qv_reg <= 1'b0;
        else if (job_push)
            qv_reg <= 1'b1;
        else if (job_pop)
            qv_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (job_push)
            q_reg <= job;
    end

    cpsat_engine #(.MAX_VERTICES(MAX_VERTICES), .COORD_WIDTH(COORD_WIDTH),
                   .CW(CW), .AW(AW)) u_engine (
        .clk(clk), .rst_n(rst_n), .we(we), .we_sel(we_sel), .waddr(waddr),
        .wdata(wdata), .job_valid(qv_reg), .job(q_reg), .cnt_a(cnt_a),
        .cnt_b(cnt_b), .job_pop(job_pop), .busy(eng_busy),
        .res_valid(done), .res_collide(collide), .res_status(status));
endmodule
`default_nettype wire

// ===== sim/tb_convex_polygon_sat_overlap.sv =====
// Testbench for the convex polygon separating-axis overlap block.
`default_nettype none
module tb_convex_polygon_sat_overlap;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXV = 16;
    localparam int CW   = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic          cmd;
        logic [CW-1:0] vx;
        logic [CW-1:0] vy;
        logic          last;
    } vertex_item_t;

    typedef struct packed {
        logic       collide;
        logic [1:0] status;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic cmd = 1'b0;
    logic [CW-1:0] vertex_x = '0;
    logic [CW-1:0] vertex_y = '0;
    logic last = 1'b0;
    logic busy, done, collide;
    logic [1:0] status;

    convex_polygon_sat_overlap #(.MAX_VERTICES(MAXV), .COORD_WIDTH(CW)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .vertex_x(vertex_x), .vertex_y(vertex_y), .last(last),
        .done(done), .collide(collide), .status(status)
    );

    always #4 clk = ~clk;

    // Shadow copy of the shape stores
    longint shp_x [2][MAXV];
    longint shp_y [2][MAXV];
    int     shp_n [2];
    bit     shp_restart [2];
    bit     shp_ovf [2];

    vertex_item_t pending_vertices[$];
    verdict_t     expected_verdicts[$];
    int  errors = 0;
    bit  quiet_tail = 0;
    bit  hold_for_drain = 0;
    bit  stim_done = 0;

    // Append one vertex to the stimulus queue
    task automatic add_vertex(vertex_item_t it);
        pending_vertices.insert(pending_vertices.size(), it);
    endtask

    // Min/max of a shape projected on axis (nx, ny)
    function automatic void project_shape(int s, longint nx, longint ny,
                                          output longint lo, output longint hi);
        longint d;
        lo = shp_x[s][0] * nx + shp_y[s][0] * ny;
        hi = lo;
        for (int i = 1; i < shp_n[s]; i++)
        begin
            d = shp_x[s][i] * nx + shp_y[s][i] * ny;
            if (d < lo) lo = d;
            if (d > hi) hi = d;
        end
    endfunction

    // True if an edge of shape s separates the two shapes
    function automatic bit edge_separates(int s);
        longint nx, ny, alo, ahi, blo, bhi;
        int j;
        for (int i = 0; i < shp_n[s]; i++)
        begin
            j = (i + 1 < shp_n[s]) ? i + 1 : 0;
            nx = -(shp_y[s][j] - shp_y[s][i]);
            ny = shp_x[s][j] - shp_x[s][i];
            project_shape(0, nx, ny, alo, ahi);
            project_shape(1, nx, ny, blo, bhi);
            if (ahi < blo || bhi < alo) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Apply one accepted vertex; queue a verdict when a job is queued
    task automatic load_vertex(vertex_item_t it);
        int s;
        verdict_t v;
        s = it.cmd;
        if (shp_restart[s])
        begin
            shp_n[s] = 0;
            shp_ovf[s] = 1'b0;
            shp_restart[s] = 1'b0;
        end
        if (shp_n[s] < MAXV)
        begin
            shp_x[s][shp_n[s]] = longint'($signed(it.vx));
            shp_y[s][shp_n[s]] = longint'($signed(it.vy));
            shp_n[s]++;
        end
        else
            shp_ovf[s] = 1'b1;
        if (it.last) shp_restart[s] = 1'b1;
        if (!(it.cmd && it.last)) return;
        v = '0;
        if (shp_n[0] == 0 || shp_n[1] == 0)
            v.status = cpsat_pkg::STATUS_EMPTY;
        else if (shp_ovf[0] || shp_ovf[1])
            v.status = cpsat_pkg::STATUS_OVF;
        else
        begin
            v.status = cpsat_pkg::STATUS_OK;
            v.collide = !(edge_separates(0) || edge_separates(1));
        end
        expected_verdicts.insert(expected_verdicts.size(), v);
    endtask

    // Driver: feeds vertices with random idle bursts
    int idle_left = 0;
    always @(posedge clk)
    begin
        vertex_item_t it;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                it = pending_vertices.pop_front();
                load_vertex(it);
            end
            if (start && busy)
                ;
            else if (idle_left > 0)
            begin
                idle_left <= idle_left - 1;
                start <= 1'b0;
            end
            else if (pending_vertices.size() == 0 ||
                     (start && !busy && pending_vertices.size() == 0) || hold_for_drain)
                start <= 1'b0;
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                idle_left <= $urandom_range(0, 4);
                start <= 1'b0;
            end
            else
            begin
                it = pending_vertices[0];
                start <= 1'b1;
                cmd <= it.cmd;
                vertex_x <= it.vx;
                vertex_y <= it.vy;
                last <= it.last;
            end
        end
    end

    // Monitor: compare each strobed verdict with the oldest expectation
    always @(posedge clk)
    begin
        verdict_t e;
        if (rst_n && done)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $display("%0t: unexpected verdict collide=%b status=%0d",
                         $realtime, collide, status);
                errors++;
            end
            else
            begin
                e = expected_verdicts.pop_front();
                if (collide !== e.collide)
                begin
                    $display("%0t: collide expected %b actual %b", $realtime,
                             e.collide, collide);
                    errors++;
                end
                if (status !== e.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $realtime,
                             e.status, status);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer and no verdict
    int stall_cycles = 0;
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n || hold_for_drain)
            stall_cycles <= 0;
        else if (!stim_done)
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [CW-1:0] rand_coord(int span);
        case ($urandom_range(0, 9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return CW'($urandom);
            default: return CW'($urandom_range(0, 2 * span) - span);
        endcase
    endfunction

    function automatic vertex_item_t mk(bit c, logic [CW-1:0] x, logic [CW-1:0] y,
                                        bit l);
        vertex_item_t it;
        it.cmd = c; it.vx = x; it.vy = y; it.last = l;
        return it;
    endfunction

    // Random shape: convex-ish box/triangle or random points
    task automatic push_shape(bit c, int n, int span);
        logic [CW-1:0] ox, oy, w, h;
        ox = CW'($urandom_range(0, 2 * span) - span);
        oy = CW'($urandom_range(0, 2 * span) - span);
        w = CW'($urandom_range(0, span));
        h = CW'($urandom_range(0, span));
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 2) == 0)
                add_vertex(mk(c, rand_coord(span), rand_coord(span), i == n - 1));
            else
                add_vertex(mk(c, ox + ((i % 4 == 1 || i % 4 == 2) ? w : CW'(0)),
                              oy + ((i % 4 >= 2) ? h : CW'(0)), i == n - 1));
        end
    endtask

    task automatic wait_drain();
        while (pending_vertices.size() != 0 || start) @(posedge clk);
        while (expected_verdicts.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        int n_items;
        int drain_cycles;
        shp_n = '{0, 0};
        shp_restart = '{1, 1};
        shp_ovf = '{0, 0};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty first shape, touching shapes, extremes, overflow
        add_vertex(mk(1, 16'd0, 16'd0, 1));
        add_vertex(mk(0, 16'd0, 16'd0, 0));
        add_vertex(mk(0, 16'd10, 16'd0, 0));
        add_vertex(mk(0, 16'd10, 16'd10, 0));
        add_vertex(mk(0, 16'd0, 16'd10, 1));
        add_vertex(mk(1, 16'd10, 16'd0, 0));
        add_vertex(mk(1, 16'd20, 16'd0, 0));
        add_vertex(mk(1, 16'd20, 16'd10, 1));
        add_vertex(mk(1, 16'd11, 16'd0, 0));
        add_vertex(mk(1, 16'd11, 16'd0, 1));
        add_vertex(mk(1, 16'h7fff, 16'h8000, 0));
        add_vertex(mk(1, 16'h8000, 16'h7fff, 1));
        for (int i = 0; i < 17; i++)
            add_vertex(mk(1, CW'(i), CW'(i), i == 16));
        wait_drain();

        // Pause: once every verdict is back, the sender holds start low
        hold_for_drain = 1;
        repeat (200) @(posedge clk);
        hold_for_drain = 0;

        // Random shapes, mostly complete pairs
        n_items = 0;
        while (n_items < 850)
        begin
            int na, nb, span;
            span = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(1, 200);
            na = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 19) : $urandom_range(1, 8);
            nb = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 19) : $urandom_range(1, 8);
            if ($urandom_range(0, 3) != 0)
            begin
                push_shape(0, na, span);
                n_items += na;
            end
            push_shape(1, nb, span);
            n_items += nb;
            if (pending_vertices.size() > 64 && n_items < 700)
                while (pending_vertices.size() > 8) @(posedge clk);
            if (n_items >= 700) quiet_tail = 1;
        end
        wait_drain();
        stim_done = 1;
        drain_cycles = 0;
        while (drain_cycles < 2000 && !done)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        @(posedge clk);
        if (errors == 0 && expected_verdicts.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
